// File: rtl/core/radix2_complex_fft_top_macros.svh
// Assertion helpers for the FFT block checker.
`ifndef RADIX2_COMPLEX_FFT_TOP_MACROS_SVH
`define RADIX2_COMPLEX_FFT_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define R2FFT_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> post) \
    else $error("r2fft checker: property failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define R2FFT_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> post) \
    else $error("r2fft checker: property failed");

`endif

// File: rtl/core/r2fft_pkg.sv
`timescale 1ns / 1ps
package r2fft_pkg;

  localparam int unsigned MAX_POINTS_DEF   = 512;
  localparam int unsigned TWIDDLE_BITS_DEF = 16;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned IDX_W    = 9;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned BIN_W    = 32;
  localparam int unsigned LOG2_W   = 4;
  localparam int unsigned CFG_IW   = 1;
  localparam int unsigned CFG_DW   = 4;
  localparam int unsigned TW_MAX_W = 24;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_RUN   = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [CFG_IW-1:0] REG_DIRECTION   = 1'd0;
  localparam logic [CFG_IW-1:0] REG_LOG2_POINTS = 1'd1;

  localparam logic [LOG2_W-1:0] LOG2_POINTS_RST = 4'd9;

  typedef enum logic [1:0] {
    ADDR_IN,
    ADDR_I,
    ADDR_K
  } addr_sel_e;

  typedef enum logic [2:0] {
    WSEL_IN,
    WSEL_SUM,
    WSEL_DIFF,
    WSEL_A,
    WSEL_B,
    WSEL_SCALE
  } wsel_e;

  typedef struct packed {
    addr_sel_e addr_sel;
    wsel_e     wsel;
    logic      we;
    logic      bfly;
    logic      cap_a;
    logic      cap_b;
    logic      tw_load;
    logic      mul;
    logic      add;
    logic      load_rd;
    logic      load_done;
  } dp_cmd_t;

  function automatic logic signed [TW_MAX_W-1:0] tw_round(logic signed [63:0] v, int f);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] r;
    logic [63:0] lim;
    neg = v < 0;
    mag = neg ? 64'(-v) : 64'(v);
    r   = (mag + (64'd1 << (29 - f))) >> (30 - f);
    lim = (64'd1 << f) - 64'd1;
    if (r > lim) begin
      r = lim;
    end
    return neg ? -TW_MAX_W'(r) : TW_MAX_W'(r);
  endfunction

  // {cos, sin} of 2*pi*k/2^lg, each TW_MAX_W bits signed, Q30 Taylor series
  function automatic logic [2*TW_MAX_W-1:0] tw_entry(int unsigned k, int unsigned lg,
                                                      int unsigned tb);
    logic [63:0]                fq;
    logic [63:0]                x;
    logic [63:0]                x2;
    logic [63:0]                term;
    logic [63:0]                cpos;
    logic [63:0]                cneg;
    logic [63:0]                spos;
    logic [63:0]                sneg;
    logic                       mirror;
    logic signed [TW_MAX_W-1:0] cw;
    logic signed [TW_MAX_W-1:0] sw;
    fq     = 64'(k) << (32 - lg);
    mirror = 1'b0;
    if (fq > (64'd1 << 30)) begin
      fq     = (64'd1 << 31) - fq;
      mirror = 1'b1;
    end
    x    = (fq * 64'd6746518852) >> 32;
    x2   = (x * x) >> 30;
    cpos = 64'd1 << 30;
    cneg = 64'd0;
    term = 64'd1 << 30;
    term = ((term * x2) >> 30) / 64'd2;   cneg = cneg + term;
    term = ((term * x2) >> 30) / 64'd12;  cpos = cpos + term;
    term = ((term * x2) >> 30) / 64'd30;  cneg = cneg + term;
    term = ((term * x2) >> 30) / 64'd56;  cpos = cpos + term;
    term = ((term * x2) >> 30) / 64'd90;  cneg = cneg + term;
    term = ((term * x2) >> 30) / 64'd132; cpos = cpos + term;
    term = ((term * x2) >> 30) / 64'd182; cneg = cneg + term;
    term = ((term * x2) >> 30) / 64'd240; cpos = cpos + term;
    term = ((term * x2) >> 30) / 64'd306; cneg = cneg + term;
    term = ((term * x2) >> 30) / 64'd380; cpos = cpos + term;
    spos = x;
    sneg = 64'd0;
    term = x;
    term = ((term * x2) >> 30) / 64'd6;   sneg = sneg + term;
    term = ((term * x2) >> 30) / 64'd20;  spos = spos + term;
    term = ((term * x2) >> 30) / 64'd42;  sneg = sneg + term;
    term = ((term * x2) >> 30) / 64'd72;  spos = spos + term;
    term = ((term * x2) >> 30) / 64'd110; sneg = sneg + term;
    term = ((term * x2) >> 30) / 64'd156; spos = spos + term;
    term = ((term * x2) >> 30) / 64'd210; sneg = sneg + term;
    term = ((term * x2) >> 30) / 64'd272; spos = spos + term;
    term = ((term * x2) >> 30) / 64'd342; sneg = sneg + term;
    term = ((term * x2) >> 30) / 64'd420; spos = spos + term;
    cw = tw_round($signed(cpos) - $signed(cneg), int'(tb) - 1);
    if (mirror) begin
      cw = -cw;
    end
    sw = tw_round($signed(spos) - $signed(sneg), int'(tb) - 1);
    return {cw, sw};
  endfunction

endpackage

// File: rtl/core/radix2_complex_fft_top.sv
// Write item: one beat, no result. Read item: result valid once the registered store
// read has passed the result register. Run item: a reorder pass over every index that
// swaps each bit-reversed pair, then N/2*m butterflies (single-port store), a scaling
// pass over all N points for an inverse, then the done beat. One item at a time.
// Reset clears control, direction to forward and log2_points to 9; store contents
// are undefined until written and are not cleared.
`timescale 1ns / 1ps
module radix2_complex_fft_top
  import r2fft_pkg::*;
#(
  parameter int unsigned MAX_POINTS   = MAX_POINTS_DEF,
  parameter int unsigned TWIDDLE_BITS = TWIDDLE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IW-1:0]          cfg_index_i,
  input  logic [CFG_DW-1:0]          cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [OP_W-1:0]            op_i,
  input  logic [IDX_W-1:0]           index_i,
  input  logic signed [SAMPLE_W-1:0] sample_re_i,
  input  logic signed [SAMPLE_W-1:0] sample_im_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       kind_o,
  output logic signed [BIN_W-1:0]    bin_re_o,
  output logic signed [BIN_W-1:0]    bin_im_o
);

  localparam int unsigned LG = $clog2(MAX_POINTS);
  localparam int unsigned SW = $clog2(LG + 1);

  dp_cmd_t       cmd;
  logic [LG-1:0] cnt;
  logic [SW-1:0] stage;
  logic [SW-1:0] m;
  logic          inverse;
  logic          swap;

  r2fft_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .swap_i      (swap),
    .cmd_o       (cmd),
    .cnt_o       (cnt),
    .stage_o     (stage),
    .m_o         (m),
    .inverse_o   (inverse)
  );

  r2fft_dp #(
    .MAX_POINTS   (MAX_POINTS),
    .TWIDDLE_BITS (TWIDDLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .cnt_i       (cnt),
    .stage_i     (stage),
    .m_i         (m),
    .inverse_i   (inverse),
    .swap_o      (swap),
    .index_i     (index_i),
    .sample_re_i (sample_re_i),
    .sample_im_i (sample_im_i),
    .kind_o      (kind_o),
    .bin_re_o    (bin_re_o),
    .bin_im_o    (bin_im_o)
  );

endmodule

// File: rtl/core/r2fft_ram.sv
`timescale 1ns / 1ps
module r2fft_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/r2fft_ctrl.sv
`timescale 1ns / 1ps
module r2fft_ctrl
  import r2fft_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  localparam int unsigned LG = $clog2(MAX_POINTS),
  localparam int unsigned SW = $clog2(LG + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   op_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  logic              swap_i,
  output dp_cmd_t           cmd_o,
  output logic [LG-1:0]     cnt_o,
  output logic [SW-1:0]     stage_o,
  output logic [SW-1:0]     m_o,
  output logic              inverse_o
);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_BR_RA,
    ST_BR_RB,
    ST_BR_LB,
    ST_BR_WA,
    ST_BR_WB,
    ST_BF_RA,
    ST_BF_RB,
    ST_BF_LB,
    ST_BF_MUL,
    ST_BF_ADD,
    ST_BF_WA,
    ST_BF_WB,
    ST_SC_RA,
    ST_SC_LA,
    ST_SC_WR,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [LG-1:0]       cnt_q;
  logic [SW-1:0]       stage_q;
  logic                out_valid_q;
  logic                dir_q;
  logic [LOG2_W-1:0]   log2_q;
  logic [SW-1:0]       m_eff;
  logic [LG-1:0]       mask_all;
  logic                last_all;
  logic                last_half;
  logic                accept;

  assign m_eff     = (log2_q > LOG2_W'(LG)) ? SW'(LG) : SW'(log2_q);
  assign mask_all  = ~({LG{1'b1}} << m_eff);
  assign last_all  = cnt_q == mask_all;
  assign last_half = cnt_q == (mask_all >> 1);

  assign in_stall_o = (state_q != ST_IDLE) ||
                      (out_valid_q && (op_i == OP_RUN || op_i == OP_READ));
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o          = '0;
    cmd_o.addr_sel = ADDR_IN;
    cmd_o.wsel     = WSEL_IN;
    case (state_q)
      ST_IDLE:    cmd_o.we = accept && (op_i == OP_WRITE);
      ST_RD_WAIT: cmd_o.load_rd = 1'b1;
      ST_BR_RA:   cmd_o.addr_sel = ADDR_I;
      ST_BR_RB: begin
        cmd_o.addr_sel = ADDR_K;
        cmd_o.cap_a    = 1'b1;
      end
      ST_BR_LB:   cmd_o.cap_b = 1'b1;
      ST_BR_WA: begin
        cmd_o.addr_sel = ADDR_I;
        cmd_o.we       = 1'b1;
        cmd_o.wsel     = WSEL_B;
      end
      ST_BR_WB: begin
        cmd_o.addr_sel = ADDR_K;
        cmd_o.we       = 1'b1;
        cmd_o.wsel     = WSEL_A;
      end
      ST_BF_RA: begin
        cmd_o.bfly     = 1'b1;
        cmd_o.addr_sel = ADDR_I;
        cmd_o.tw_load  = 1'b1;
      end
      ST_BF_RB: begin
        cmd_o.bfly     = 1'b1;
        cmd_o.addr_sel = ADDR_K;
        cmd_o.cap_a    = 1'b1;
      end
      ST_BF_LB:   cmd_o.cap_b = 1'b1;
      ST_BF_MUL:  cmd_o.mul = 1'b1;
      ST_BF_ADD:  cmd_o.add = 1'b1;
      ST_BF_WA: begin
        cmd_o.bfly     = 1'b1;
        cmd_o.addr_sel = ADDR_I;
        cmd_o.we       = 1'b1;
        cmd_o.wsel     = WSEL_SUM;
      end
      ST_BF_WB: begin
        cmd_o.bfly     = 1'b1;
        cmd_o.addr_sel = ADDR_K;
        cmd_o.we       = 1'b1;
        cmd_o.wsel     = WSEL_DIFF;
      end
      ST_SC_RA:   cmd_o.addr_sel = ADDR_I;
      ST_SC_LA:   cmd_o.cap_a = 1'b1;
      ST_SC_WR: begin
        cmd_o.addr_sel = ADDR_I;
        cmd_o.we       = 1'b1;
        cmd_o.wsel     = WSEL_SCALE;
      end
      ST_DONE:    cmd_o.load_done = 1'b1;
      default:    cmd_o.addr_sel = ADDR_IN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      stage_q     <= '0;
      out_valid_q <= 1'b0;
      dir_q       <= 1'b0;
      log2_q      <= LOG2_POINTS_RST;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_DIRECTION:   dir_q  <= cfg_wdata_i[0];
          REG_LOG2_POINTS: log2_q <= cfg_wdata_i;
          default:         dir_q  <= dir_q;
        endcase
      end

      if (state_q == ST_RD_WAIT || state_q == ST_DONE) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (accept && op_i == OP_READ) begin
            state_q <= ST_RD_WAIT;
          end else if (accept && op_i == OP_RUN) begin
            state_q <= (m_eff == '0) ? ST_DONE : ST_BR_RA;
          end
        end
        ST_RD_WAIT: state_q <= ST_IDLE;
        ST_BR_RA: begin
          if (swap_i) begin
            state_q <= ST_BR_RB;
          end else if (last_all) begin
            cnt_q   <= '0;
            stage_q <= SW'(1);
            state_q <= ST_BF_RA;
          end else begin
            cnt_q <= cnt_q + LG'(1);
          end
        end
        ST_BR_RB: state_q <= ST_BR_LB;
        ST_BR_LB: state_q <= ST_BR_WA;
        ST_BR_WA: state_q <= ST_BR_WB;
        ST_BR_WB: begin
          if (last_all) begin
            cnt_q   <= '0;
            stage_q <= SW'(1);
            state_q <= ST_BF_RA;
          end else begin
            cnt_q   <= cnt_q + LG'(1);
            state_q <= ST_BR_RA;
          end
        end
        ST_BF_RA:  state_q <= ST_BF_RB;
        ST_BF_RB:  state_q <= ST_BF_LB;
        ST_BF_LB:  state_q <= ST_BF_MUL;
        ST_BF_MUL: state_q <= ST_BF_ADD;
        ST_BF_ADD: state_q <= ST_BF_WA;
        ST_BF_WA:  state_q <= ST_BF_WB;
        ST_BF_WB: begin
          if (!last_half) begin
            cnt_q   <= cnt_q + LG'(1);
            state_q <= ST_BF_RA;
          end else if (stage_q == m_eff) begin
            cnt_q   <= '0;
            state_q <= dir_q ? ST_SC_RA : ST_DONE;
          end else begin
            cnt_q   <= '0;
            stage_q <= stage_q + SW'(1);
            state_q <= ST_BF_RA;
          end
        end
        ST_SC_RA: state_q <= ST_SC_LA;
        ST_SC_LA: state_q <= ST_SC_WR;
        ST_SC_WR: begin
          cnt_q   <= cnt_q + LG'(1);
          state_q <= last_all ? ST_DONE : ST_SC_RA;
        end
        ST_DONE: state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign cnt_o       = cnt_q;
  assign stage_o     = stage_q;
  assign m_o         = m_eff;
  assign inverse_o   = dir_q;

endmodule

// File: rtl/core/r2fft_dp.sv
`timescale 1ns / 1ps
module r2fft_dp
  import r2fft_pkg::*;
#(
  parameter int unsigned MAX_POINTS   = MAX_POINTS_DEF,
  parameter int unsigned TWIDDLE_BITS = TWIDDLE_BITS_DEF,
  localparam int unsigned LG   = $clog2(MAX_POINTS),
  localparam int unsigned SW   = $clog2(LG + 1),
  localparam int unsigned HALF = MAX_POINTS / 2,
  localparam int unsigned KW   = (LG > 1) ? LG - 1 : 1
) (
  input  logic                       clk_i,
  input  dp_cmd_t                    cmd_i,
  input  logic [LG-1:0]              cnt_i,
  input  logic [SW-1:0]              stage_i,
  input  logic [SW-1:0]              m_i,
  input  logic                       inverse_i,
  output logic                       swap_o,
  input  logic [IDX_W-1:0]           index_i,
  input  logic signed [SAMPLE_W-1:0] sample_re_i,
  input  logic signed [SAMPLE_W-1:0] sample_im_i,
  output logic                       kind_o,
  output logic signed [BIN_W-1:0]    bin_re_o,
  output logic signed [BIN_W-1:0]    bin_im_o
);

  localparam int unsigned TB = TWIDDLE_BITS;
  localparam int unsigned F  = TB - 1;
  localparam int unsigned PW = TB + BIN_W;
  localparam int unsigned TW = PW + 1 - F;
  localparam logic signed [PW:0] RND = (PW + 1)'(1) << (F - 1);

  logic signed [TB-1:0] rom_cos [HALF];
  logic signed [TB-1:0] rom_sin [HALF];

  for (genvar g = 0; g < HALF; g++) begin : g_rom
    localparam logic [2*TW_MAX_W-1:0] ENTRY = tw_entry(g, LG, TB);
    assign rom_cos[g] = ENTRY[TW_MAX_W +: TB];
    assign rom_sin[g] = ENTRY[0 +: TB];
  end

  logic [LG+IDX_W-1:0]      idx_ext;
  logic [LG-1:0]            rev_full;
  logic [LG-1:0]            rev;
  logic [LG-1:0]            mask_lo;
  logic [LG-1:0]            bf_i;
  logic [LG-1:0]            bf_k;
  logic [LG-1:0]            tw_idx;
  logic [LG-1:0]            addr;
  logic [2*BIN_W-1:0]       wdata;
  logic [2*BIN_W-1:0]       rdata;
  logic [2*BIN_W-1:0]       a_q;
  logic [2*BIN_W-1:0]       b_q;
  logic signed [TB-1:0]     tw_re_q;
  logic signed [TB-1:0]     tw_im_q;
  logic signed [PW-1:0]     p_q [4];
  logic signed [TW-1:0]     t_re_q;
  logic signed [TW-1:0]     t_im_q;
  logic signed [PW:0]       sum_re;
  logic signed [PW:0]       sum_im;
  logic signed [BIN_W-1:0]  a_re;
  logic signed [BIN_W-1:0]  a_im;
  logic signed [BIN_W-1:0]  b_re;
  logic signed [BIN_W-1:0]  b_im;
  logic                     kind_q;
  logic signed [BIN_W-1:0]  bin_re_q;
  logic signed [BIN_W-1:0]  bin_im_q;

  function automatic logic signed [BIN_W-1:0] sat32(logic signed [TW:0] v);
    if (v[TW:BIN_W-1] == {(TW - BIN_W + 2){v[TW]}}) begin
      return v[BIN_W-1:0];
    end
    return v[TW] ? {1'b1, {(BIN_W - 1){1'b0}}} : {1'b0, {(BIN_W - 1){1'b1}}};
  endfunction

  assign idx_ext = (LG + IDX_W)'(index_i);

  always_comb begin
    for (int b = 0; b < LG; b++) begin
      rev_full[b] = cnt_i[LG-1-b];
    end
  end
  assign rev    = rev_full >> (SW'(LG) - m_i);
  assign swap_o = cnt_i < rev;

  assign mask_lo = ~({LG{1'b1}} << (stage_i - SW'(1)));
  assign bf_i    = ((cnt_i & ~mask_lo) << 1) | (cnt_i & mask_lo);
  assign bf_k    = bf_i | (mask_lo + LG'(1));
  assign tw_idx  = (cnt_i & mask_lo) << (SW'(LG) - stage_i);

  always_comb begin
    case (cmd_i.addr_sel)
      ADDR_IN: addr = idx_ext[LG-1:0];
      ADDR_I:  addr = cmd_i.bfly ? bf_i : cnt_i;
      ADDR_K:  addr = cmd_i.bfly ? bf_k : rev;
      default: addr = idx_ext[LG-1:0];
    endcase
  end

  assign a_re = a_q[2*BIN_W-1:BIN_W];
  assign a_im = a_q[BIN_W-1:0];
  assign b_re = b_q[2*BIN_W-1:BIN_W];
  assign b_im = b_q[BIN_W-1:0];

  always_comb begin
    case (cmd_i.wsel)
      WSEL_IN:    wdata = {BIN_W'(sample_re_i), BIN_W'(sample_im_i)};
      WSEL_SUM:   wdata = {sat32((TW + 1)'(a_re) + (TW + 1)'(t_re_q)),
                           sat32((TW + 1)'(a_im) + (TW + 1)'(t_im_q))};
      WSEL_DIFF:  wdata = {sat32((TW + 1)'(a_re) - (TW + 1)'(t_re_q)),
                           sat32((TW + 1)'(a_im) - (TW + 1)'(t_im_q))};
      WSEL_A:     wdata = a_q;
      WSEL_B:     wdata = b_q;
      WSEL_SCALE: wdata = {a_re >>> m_i, a_im >>> m_i};
      default:    wdata = a_q;
    endcase
  end

  r2fft_ram #(
    .WIDTH (2 * BIN_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.we),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  assign sum_re = (PW + 1)'(p_q[0]) - (PW + 1)'(p_q[1]) + RND;
  assign sum_im = (PW + 1)'(p_q[2]) + (PW + 1)'(p_q[3]) + RND;

  always_ff @(posedge clk_i) begin
    if (cmd_i.tw_load) begin
      tw_re_q <= rom_cos[tw_idx[KW-1:0]];
      tw_im_q <= inverse_i ? rom_sin[tw_idx[KW-1:0]] : -rom_sin[tw_idx[KW-1:0]];
    end
    if (cmd_i.cap_a) begin
      a_q <= rdata;
    end
    if (cmd_i.cap_b) begin
      b_q <= rdata;
    end
    if (cmd_i.mul) begin
      p_q[0] <= tw_re_q * b_re;
      p_q[1] <= tw_im_q * b_im;
      p_q[2] <= tw_re_q * b_im;
      p_q[3] <= tw_im_q * b_re;
    end
    if (cmd_i.add) begin
      t_re_q <= sum_re[PW:F];
      t_im_q <= sum_im[PW:F];
    end
    if (cmd_i.load_rd) begin
      kind_q   <= 1'b0;
      bin_re_q <= rdata[2*BIN_W-1:BIN_W];
      bin_im_q <= rdata[BIN_W-1:0];
    end else if (cmd_i.load_done) begin
      kind_q   <= 1'b1;
      bin_re_q <= '0;
      bin_im_q <= '0;
    end
  end

  assign kind_o   = kind_q;
  assign bin_re_o = bin_re_q;
  assign bin_im_o = bin_im_q;

endmodule

// File: rtl/core/r2fft_checker.sv
`timescale 1ns / 1ps
`include "radix2_complex_fft_top_macros.svh"
module r2fft_checker
  import r2fft_pkg::*;
(
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic [OP_W-1:0]            op_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic                       kind_o,
  input logic signed [BIN_W-1:0]    bin_re_o,
  input logic signed [BIN_W-1:0]    bin_im_o
);

  logic in_beat;

  assign in_beat = in_valid_i && !in_stall_o;

  `R2FFT_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i,
    (out_valid_o && $stable(kind_o) && $stable(bin_re_o) && $stable(bin_im_o)))
  `R2FFT_ASSERT_IMP(a_read_result, in_beat && op_i == OP_READ,
    ##2 (out_valid_o && kind_o == 1'b0))
  `R2FFT_ASSERT_NXT(a_write_silent, in_beat && op_i == OP_WRITE && !out_valid_o,
    (!out_valid_o))
  `R2FFT_ASSERT_IMP(a_done_zero, out_valid_o && kind_o,
    (bin_re_o == '0 && bin_im_o == '0))

endmodule

bind radix2_complex_fft_top r2fft_checker u_checker (.*);

// File: dv/radix2_complex_fft_top_test.sv
`timescale 1ns / 1ps
module radix2_complex_fft_top_test;
  import r2fft_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int TW_F = TWIDDLE_BITS_DEF - 1;
  localparam int NPTS = MAX_POINTS_DEF;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct {
    logic              kind;
    logic signed [31:0] re;
    logic signed [31:0] im;
  } bin_beat_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [CFG_IW-1:0]          cfg_index_i = '0;
  logic [CFG_DW-1:0]          cfg_wdata_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [OP_W-1:0]            op_i = '0;
  logic [IDX_W-1:0]           index_i = '0;
  logic signed [SAMPLE_W-1:0] sample_re_i = '0;
  logic signed [SAMPLE_W-1:0] sample_im_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic                       kind_o;
  logic signed [BIN_W-1:0]    bin_re_o;
  logic signed [BIN_W-1:0]    bin_im_o;

  radix2_complex_fft_top dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  int        point_re [NPTS];
  int        point_im [NPTS];
  bit        point_set [NPTS];
  bit        inverse_q;
  int        log2_q;
  bin_beat_t pending_bins [$];
  int        errors;
  int        items_sent;
  int        runs_done;
  int        bins_checked;
  bit        calm;
  int        hold_left;
  int        idle_cycles;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint q15_round(longint v);
    longint     mag;
    longint     r;
    mag = (v < 0) ? -v : v;
    r = (mag + (64'sd1 << (29 - TW_F))) >>> (30 - TW_F);
    if (r > (64'sd1 << TW_F) - 1) r = (64'sd1 << TW_F) - 1;
    return (v < 0) ? -r : r;
  endfunction

  task automatic twiddle(input int unsigned j, input int unsigned s,
                         output longint c, output longint sn);
    logic [63:0] fq, x, x2, term, cp, cn, sp, sg;
    bit          mirror;
    fq = 64'(j) << (32 - s);
    mirror = 1'b0;
    if (fq > (64'd1 << 30)) begin
      fq = (64'd1 << 31) - fq;
      mirror = 1'b1;
    end
    x = (fq * 64'd6746518852) >> 32;
    x2 = (x * x) >> 30;
    cp = 64'd1 << 30;
    cn = 0;
    term = 64'd1 << 30;
    for (int n = 1; n <= 10; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n % 2) cn += term;
      else cp += term;
    end
    sp = x;
    sg = 0;
    term = x;
    for (int n = 1; n <= 10; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2) sg += term;
      else sp += term;
    end
    c = q15_round(longint'(cp) - longint'(cn));
    if (mirror) c = -c;
    sn = q15_round(longint'(sp) - longint'(sg));
  endtask

  function automatic int eff_log2();
    return (log2_q > 9) ? 9 : log2_q;
  endfunction

  task automatic transform_store();
    int     m, n, r, t, half, span, k;
    longint wr, wi, ar, ai, br, bi, tr, ti;
    m = eff_log2();
    n = 1 << m;
    for (int i = 0; i < n; i++) begin
      r = 0;
      for (int b = 0; b < m; b++) if (i & (1 << b)) r |= 1 << (m - 1 - b);
      if (i < r) begin
        t = point_re[i]; point_re[i] = point_re[r]; point_re[r] = t;
        t = point_im[i]; point_im[i] = point_im[r]; point_im[r] = t;
      end
    end
    for (int s = 1; s <= m; s++) begin
      half = 1 << (s - 1);
      span = 1 << s;
      for (int j = 0; j < half; j++) begin
        twiddle(j, s, wr, wi);
        if (!inverse_q) wi = -wi;
        for (int i = j; i < n; i += span) begin
          k = i + half;
          br = point_re[k]; bi = point_im[k];
          ar = point_re[i]; ai = point_im[i];
          tr = (wr * br - wi * bi + (64'sd1 << (TW_F - 1))) >>> TW_F;
          ti = (wr * bi + wi * br + (64'sd1 << (TW_F - 1))) >>> TW_F;
          point_re[k] = int'(sat32(ar - tr));
          point_im[k] = int'(sat32(ai - ti));
          point_re[i] = int'(sat32(ar + tr));
          point_im[i] = int'(sat32(ai + ti));
        end
      end
    end
    if (inverse_q)
      for (int i = 0; i < n; i++) begin
        point_re[i] = point_re[i] >>> m;
        point_im[i] = point_im[i] >>> m;
      end
  endtask

  task automatic predict_item(logic [OP_W-1:0] op, int idx, int re, int im);
    bin_beat_t b;
    case (op)
      OP_WRITE: begin
        point_re[idx] = re;
        point_im[idx] = im;
        point_set[idx] = 1'b1;
      end
      OP_RUN: begin
        transform_store();
        b.kind = 1'b1; b.re = 0; b.im = 0;
        pending_bins.push_back(b);
      end
      OP_READ: begin
        b.kind = 1'b0; b.re = point_re[idx]; b.im = point_im[idx];
        pending_bins.push_back(b);
      end
      default: ;
    endcase
  endtask

  task automatic send_item(logic [OP_W-1:0] op, int idx, int re = 0, int im = 0);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    op_i <= op;
    index_i <= idx[IDX_W-1:0];
    sample_re_i <= re[15:0];
    sample_im_i <= im[15:0];
    do @(posedge clk_i); while (in_stall_o);
    predict_item(op, idx % NPTS, 32'(signed'(re[15:0])), 32'(signed'(im[15:0])));
    if (op != OP_NONE) items_sent++;
    if (!calm && $urandom_range(0, 99) < 22) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [CFG_IW-1:0] idx, int val);
    drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val[CFG_DW-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_DIRECTION) inverse_q = val[0];
    else log2_q = val[3:0];
  endtask

  function automatic int rand_sample();
    case ($urandom_range(0, 9))
      0: return -32768;
      1: return 32767;
      default: return int'(signed'(16'($urandom)));
    endcase
  endfunction

  function automatic int written_index();
    int i;
    i = $urandom_range(0, NPTS - 1);
    while (!point_set[i]) i = (i + 1) % NPTS;
    return i;
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    errors++;
    $display("mismatch %s: expected %0d got %0d", what, want, got);
  endtask

  always @(posedge clk_i) begin
    bin_beat_t b;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_bins.size() == 0) begin
        errors++;
        $display("unexpected result beat kind %0d", kind_o);
      end else begin
        b = pending_bins.pop_front();
        bins_checked++;
        if (kind_o !== b.kind) report_mismatch("kind", b.kind, kind_o);
        if (bin_re_o !== b.re) report_mismatch("bin_re", b.re, bin_re_o);
        if (bin_im_o !== b.im) report_mismatch("bin_im", b.im, bin_im_o);
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (calm) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 22);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results pending", pending_bins.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic test_directed();
    set_reg(REG_LOG2_POINTS, 1);
    set_reg(REG_DIRECTION, 0);
    send_item(OP_WRITE, 0, 32767, -32768);
    send_item(OP_WRITE, 1, -32768, 32767);
    send_item(OP_READ, 0);
    send_item(OP_RUN, 0);
    send_item(OP_READ, 0);
    send_item(OP_READ, 1);
    send_item(OP_NONE, 1, -1, -1);
    set_reg(REG_DIRECTION, 1);
    send_item(OP_RUN, 0);
    send_item(OP_READ, 0);
    send_item(OP_READ, 1);
    send_item(OP_WRITE, 511, -32768, -32768);
    send_item(OP_READ, 511);
    send_item(OP_WRITE, 511, 32767, 32767);
    send_item(OP_READ, 511);
    set_reg(REG_LOG2_POINTS, 0);
    send_item(OP_RUN, 0);
    send_item(OP_READ, 0);
    set_reg(REG_DIRECTION, 0);
    send_item(OP_RUN, 0);
    send_item(OP_READ, 0);
  endtask

  task automatic run_segment(int m, bit inv);
    int n;
    if (m != log2_q) set_reg(REG_LOG2_POINTS, m);
    if (inv != inverse_q) set_reg(REG_DIRECTION, inv);
    n = 1 << eff_log2();
    if ($urandom_range(0, 99) < 75) begin
      for (int i = 0; i < n; i++) begin
        send_item(OP_WRITE, i, rand_sample(), rand_sample());
        case ($urandom_range(0, 19))
          0: send_item(OP_NONE, $urandom_range(0, NPTS - 1), rand_sample(), rand_sample());
          1: send_item(OP_WRITE, $urandom_range(0, NPTS - 1), rand_sample(), rand_sample());
          2: send_item(OP_READ, written_index());
          default: ;
        endcase
      end
    end else begin
      for (int i = 0; i < n; i++)
        if (!point_set[i]) send_item(OP_WRITE, i, rand_sample(), rand_sample());
    end
    send_item(OP_RUN, $urandom_range(0, NPTS - 1), rand_sample(), rand_sample());
    repeat ($urandom_range(1, (n < 8) ? n + 1 : 8)) send_item(OP_READ, $urandom_range(0, n - 1));
    if ($urandom_range(0, 3) == 0) send_item(OP_READ, written_index());
  endtask

  task automatic test_random();
    int big;
    int r;
    big = 0;
    while (items_sent < 1400) begin
      calm = (items_sent >= 600 && items_sent < 800);
      r = $urandom_range(0, 99);
      if (r < 6) run_segment(0, $urandom_range(0, 1));
      else if (r < 90) run_segment($urandom_range(1, 5), $urandom_range(0, 1));
      else if (r < 95) run_segment($urandom_range(6, 8), $urandom_range(0, 1));
      else if (big < 2) begin
        run_segment(big ? 15 : 9, big[0]);
        big++;
      end else run_segment(3, $urandom_range(0, 1));
    end
    calm = 1'b0;
  endtask

  task automatic test_backpressure();
    drain();
    hold_left = 400;
    for (int i = 0; i < 30; i++) send_item(OP_READ, written_index());
    send_item(OP_RUN, 0);
    for (int i = 0; i < 10; i++) send_item(OP_READ, written_index());
  endtask

  initial begin
    errors = 0;
    items_sent = 0;
    bins_checked = 0;
    calm = 1'b0;
    hold_left = 0;
    idle_cycles = 0;
    inverse_q = 1'b0;
    log2_q = LOG2_POINTS_RST;
    for (int i = 0; i < NPTS; i++) begin
      point_re[i] = 0;
      point_im[i] = 0;
      point_set[i] = 1'b0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random();
    test_backpressure();
    drain();
    repeat (20) @(posedge clk_i);
    if (pending_bins.size() != 0) begin
      errors++;
      $display("%0d results never arrived", pending_bins.size());
    end
    $display("covered %0d items: writes, reads, forward and inverse runs at sizes 1 to 512",
             items_sent);
    $display("checked %0d result beats, including a long output hold-off", bins_checked);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
